// ===== sv/b64sc_pkg.sv =====
// b64sc_pkg: shared types, codes and alphabet functions for the Base64 codec.
// Standalone package; imported by base64_stream_codec.
`default_nettype none
package b64sc_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = 3;

  // Group position codes
  localparam logic [1:0] GP_FIRST  = 2'd0;
  localparam logic [1:0] GP_SECOND = 2'd1;
  localparam logic [1:0] GP_THIRD  = 2'd2;
  localparam logic [1:0] GP_FOURTH = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       last;
    logic       bad_char;
  } res_t;

  // Map a 6-bit value to its alphabet character.
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26)      c = 8'h41 + {2'b00, v};
    else if (v < 6'd52) c = 8'h61 + {2'b00, v - 6'd26};
    else if (v < 6'd62) c = 8'h30 + {2'b00, v - 6'd52};
    else if (v == 6'd62) c = 8'h2B;
    else                 c = 8'h2F;
    return c;
  endfunction

  // Map a character to its 6-bit value; bit 6 set means outside the alphabet.
  function automatic logic [6:0] dec_value(input logic [7:0] c);
    logic [6:0] v;
    if (c >= 8'h41 && c <= 8'h5A)      v = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
    else if (c == 8'h2B)               v = 7'd62;
    else if (c == 8'h2F)               v = 7'd63;
    else                               v = 7'd64;
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/base64_stream_codec.sv =====
// base64_stream_codec: Base64 (RFC 4648) stream encoder/decoder, top level.
// Depends on b64sc_pkg for the alphabet functions, codes and result type.
//
// Usage:
//   in_*  : input beats. in_tdata = data_in (byte to encode or character to
//           decode), in_tlast = last_in, closing the message.
//   out_* : result beats. out_tdata = data_out, out_tlast = last_out,
//           out_tuser[0] = has_data, out_tuser[1] = bad_char.
//   cfg_wr_en/cfg_wr_data write the mode register (0 encode, 1 decode) and
//   clear the group state; write only while the block is idle.
// Timing:
//   An accepted beat is worked out in the same cycle and its results (zero to
//   four) land in a four-entry result buffer; the first result is on out_* the
//   cycle after acceptance. The buffer drains one beat per cycle while the
//   receiver takes them, and a new input beat is taken only once the buffer
//   is empty or in the cycle the last buffered result leaves, so the block
//   takes no new beat while earlier results still wait behind the head.
// Reset (rst_n low, synchronous) selects encode mode, clears the group state
// and empties the buffer. When the receiver stalls, the buffer holds its
// contents and in_tready drops until the final buffered result is taken.
`default_nettype none
module base64_stream_codec (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_in
  input  wire logic       in_tlast,   // last_in
  // result channel
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] data_out
  output logic            out_tlast,  // last_out
  output logic [1:0]      out_tuser,  // [0] has_data, [1] bad_char
  // configuration
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data // mode
);
  import b64sc_pkg::*;

  logic             mode_r;
  logic [1:0]       gp_r, gp_nxt;
  logic [5:0]       carry_r, carry_nxt;
  logic             halt_r, halt_nxt;
  res_t             res_r   [MAX_RES];
  res_t             res_nxt [MAX_RES];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic in_acc, out_acc;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = res_r[0].data;
  assign out_tlast  = res_r[0].last;
  assign out_tuser  = {res_r[0].bad_char, res_r[0].has_data};

  assign out_acc   = out_tvalid && out_tready;
  // Take the next beat once the buffer is empty or its final entry leaves now.
  assign in_tready = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // Work out all results of the incoming beat and the next group state.
  always_comb begin
    logic [6:0] dv;
    logic [7:0] b;
    b   = in_tdata;
    dv  = dec_value(b);
    gp_nxt    = gp_r;
    carry_nxt = carry_r;
    halt_nxt  = halt_r;
    cnt_nxt   = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      res_nxt[i] = '0;
    end

    if (mode_r == MODE_ENCODE) begin
      case (gp_r)
        GP_FIRST: begin
          res_nxt[0] = '{enc_char(b[7:2]), 1'b1, 1'b0, 1'b0};
          carry_nxt  = {4'b0, b[1:0]};
          gp_nxt     = GP_SECOND;
          cnt_nxt    = CNT_W'(1);
          if (in_tlast) begin
            res_nxt[1] = '{enc_char({b[1:0], 4'b0}), 1'b1, 1'b0, 1'b0};
            res_nxt[2] = '{PAD_CHAR, 1'b1, 1'b0, 1'b0};
            res_nxt[3] = '{PAD_CHAR, 1'b1, 1'b0, 1'b0};
            cnt_nxt    = CNT_W'(4);
          end
        end
        GP_SECOND: begin
          res_nxt[0] = '{enc_char({carry_r[1:0], b[7:4]}), 1'b1, 1'b0, 1'b0};
          carry_nxt  = {2'b0, b[3:0]};
          gp_nxt     = GP_THIRD;
          cnt_nxt    = CNT_W'(1);
          if (in_tlast) begin
            res_nxt[1] = '{enc_char({b[3:0], 2'b0}), 1'b1, 1'b0, 1'b0};
            res_nxt[2] = '{PAD_CHAR, 1'b1, 1'b0, 1'b0};
            cnt_nxt    = CNT_W'(3);
          end
        end
        default: begin
          res_nxt[0] = '{enc_char({carry_r[3:0], b[7:6]}), 1'b1, 1'b0, 1'b0};
          res_nxt[1] = '{enc_char(b[5:0]), 1'b1, 1'b0, 1'b0};
          carry_nxt  = '0;
          gp_nxt     = GP_FIRST;
          cnt_nxt    = CNT_W'(2);
        end
      endcase
    end else if (!halt_r) begin
      if (dv[6]) begin
        halt_nxt = 1'b1;
      end else begin
        case (gp_r)
          GP_FIRST: begin
            carry_nxt = dv[5:0];
            gp_nxt    = GP_SECOND;
          end
          GP_SECOND: begin
            res_nxt[0] = '{{carry_r[5:0], dv[5:4]}, 1'b1, 1'b0, 1'b0};
            carry_nxt  = {2'b0, dv[3:0]};
            gp_nxt     = GP_THIRD;
            cnt_nxt    = CNT_W'(1);
          end
          GP_THIRD: begin
            res_nxt[0] = '{{carry_r[3:0], dv[5:2]}, 1'b1, 1'b0, 1'b0};
            carry_nxt  = {4'b0, dv[1:0]};
            gp_nxt     = GP_FOURTH;
            cnt_nxt    = CNT_W'(1);
          end
          default: begin
            res_nxt[0] = '{{carry_r[1:0], dv[5:0]}, 1'b1, 1'b0, 1'b0};
            carry_nxt  = '0;
            gp_nxt     = GP_FIRST;
            cnt_nxt    = CNT_W'(1);
          end
        endcase
      end
    end

    // End of message: mark the final result (bare if none) and, in decode mode, its bad_char flag, then clear state.
    if (in_tlast) begin
      if (cnt_nxt == '0) begin
        cnt_nxt = CNT_W'(1);
      end
      for (int i = 0; i < MAX_RES; i++) begin
        if (CNT_W'(i + 1) == cnt_nxt) begin
          res_nxt[i].last     = 1'b1;
          res_nxt[i].bad_char = (mode_r == MODE_DECODE) ? halt_nxt : 1'b0;
        end
      end
      gp_nxt    = GP_FIRST;
      carry_nxt = '0;
      halt_nxt  = 1'b0;
    end
  end

  // Control state: mode, group state and buffer fill.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ENCODE;
      gp_r    <= GP_FIRST;
      carry_r <= '0;
      halt_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r  <= cfg_wr_data;
        gp_r    <= GP_FIRST;
        carry_r <= '0;
        halt_r  <= 1'b0;
      end else if (in_acc) begin
        gp_r    <= gp_nxt;
        carry_r <= carry_nxt;
        halt_r  <= halt_nxt;
      end
      if (in_acc) begin
        cnt_r <= cnt_nxt;
      end else if (out_acc) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Result buffer payload: load on accept, advance one entry per taken beat.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RES))
    else $error("result buffer count out of range");

  a_last_yields: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> out_tvalid)
    else $error("final input beat produced no result");

  a_last_is_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> cnt_r == CNT_W'(1))
    else $error("last result is not the tail of the buffer");

  a_enc_no_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mode_r == MODE_ENCODE |-> !out_tuser[1])
    else $error("bad_char set in encode mode");

  a_enc_gp: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_ENCODE |-> gp_r != GP_FOURTH)
    else $error("encoder reached fourth group position");
`endif

endmodule
`default_nettype wire
